FILE: design/assert_macros.svh
// Assertion macros for the converter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: design/pcsc_pkg.sv
// Package for the pixel color space converter: widths, mode codes, stage types.
// No dependencies; imported by pcsc_div, pixel_color_space_converter, pcsc_checker and the testbench.
package pcsc_pkg;

  localparam int CH_W      = 8;
  localparam int MODE_W    = 3;
  localparam int NUM_W     = 26;  // largest dividend: 765 * 65025
  localparam int DEN_W     = 18;  // largest divisor: 765 * 255
  localparam int DIV_STEPS = 4;   // two quotient bits per step
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int PIPE_LAT  = 3 + DIV_LAT + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS    = 3'd0,
    MODE_RGB_HSL = 3'd1,
    MODE_RGB_HSV = 3'd2,
    MODE_HSV_HSL = 3'd3,
    MODE_HSL_HSV = 3'd4,
    MODE_HSL_RGB = 3'd5,
    MODE_HSV_RGB = 3'd6
  } mode_e;

  // HSL to RGB: which piece of the channel curve a hue lands on
  typedef enum logic [1:0] {
    SEG_RAMP = 2'd0,
    SEG_Q    = 2'd1,
    SEG_P    = 2'd2
  } hsl_seg_e;

  // HSV to RGB: which of v, p, q, t a channel takes
  typedef enum logic [1:0] {
    PICK_V = 2'd0,
    PICK_P = 2'd1,
    PICK_Q = 2'd2,
    PICK_T = 2'd3
  } hsv_pick_e;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [CH_W-1:0]       a;
    logic [CH_W-1:0]       b;
    logic [CH_W-1:0]       c;
    logic [CH_W-1:0]       alpha;
    logic [CH_W-1:0]       mx;
    logic [CH_W-1:0]       d;
    logic [CH_W:0]         s;
    logic [10:0]           hn;
    logic [15:0]           cb;
    logic [16:0]           l;
    logic [6:0]            lo4;
    logic [2:0]            sec;
    logic [CH_W-1:0]       f;
    logic [2:0][9:0]       t;
  } s1_t;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [CH_W-1:0]       a;
    logic [CH_W-1:0]       b;
    logic [CH_W-1:0]       c;
    logic [CH_W-1:0]       alpha;
    logic [CH_W-1:0]       mx;
    logic [CH_W-1:0]       d;
    logic [CH_W:0]         s;
    logic [10:0]           hn;
    logic [16:0]           l;
    logic [16:0]           lo3;
    logic [23:0]           n3;
    logic [14:0]           blo;
    logic [15:0]           q;
    logic [15:0]           p;
    logic [15:0]           qmp;
    logic [2:0][1:0]       seg;
    logic [2:0][9:0]       k;
    logic [15:0]           kp;
    logic [15:0]           kq;
    logic [15:0]           kt;
    logic [2:0]            sec;
  } s2_t;

endpackage

FILE: design/pcsc_div.sv
// Pipelined saturating divider: quotient = min(255, num / den), 0 when den is 0.
// Depends on pcsc_pkg for widths and step count.
module pcsc_div import pcsc_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [CH_W-1:0]  quot_o
);

  logic [NUM_W-1:0] rem_q [DIV_LAT];
  logic [DEN_W-1:0] den_q [DIV_LAT];
  logic [CH_W-1:0]  quo_q [DIV_LAT];
  logic             sat_q [DIV_LAT];

  // entry: saturation check; a zero divisor becomes 0 / 1
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= (den_i == '0) ? '0 : num_i;
      den_q[0] <= (den_i == '0) ? DEN_W'(1) : den_i;
      quo_q[0] <= '0;
      sat_q[0] <= (den_i != '0) && (num_i >= {den_i, 8'b0});
    end
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_step
    localparam int Hi = 2 * (DIV_STEPS - j) + 1;
    logic [NUM_W-1:0] sub_hi, sub_lo, rem_mid, rem_d;
    logic             bit_hi, bit_lo;

    always_comb begin
      sub_hi  = NUM_W'(den_q[j-1]) << Hi;
      sub_lo  = NUM_W'(den_q[j-1]) << (Hi - 1);
      bit_hi  = rem_q[j-1] >= sub_hi;
      rem_mid = bit_hi ? rem_q[j-1] - sub_hi : rem_q[j-1];
      bit_lo  = rem_mid >= sub_lo;
      rem_d   = bit_lo ? rem_mid - sub_lo : rem_mid;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        den_q[j] <= den_q[j-1];
        quo_q[j] <= quo_q[j-1] | (CH_W'({bit_hi, bit_lo}) << (Hi - 1));
        sat_q[j] <= sat_q[j-1];
      end
    end
  end

  assign quot_o = sat_q[DIV_LAT-1] ? '1 : quo_q[DIV_LAT-1];

endmodule

FILE: design/pixel_color_space_converter.sv
// Pixel color space converter: one pixel (three channel bytes plus alpha) per
// clock, converted between RGB, HSL and HSV as the 3-bit mode register selects.
// Fully pipelined: a new word is taken every cycle while the output side takes
// results. Three pre-compute stages form exact numerators and divisors, then one
// five-stage divider per channel yields the saturated floor quotient. Write the
// mode only while idle.
`include "assert_macros.svh"

module pixel_color_space_converter import pcsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [MODE_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CH_W-1:0]   chan_a_i,
  input  logic [CH_W-1:0]   chan_b_i,
  input  logic [CH_W-1:0]   chan_c_i,
  input  logic [CH_W-1:0]   alpha_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CH_W-1:0]   res_a_o,
  output logic [CH_W-1:0]   res_b_o,
  output logic [CH_W-1:0]   res_c_o,
  output logic [CH_W-1:0]   alpha_out_o
);

  logic [MODE_W-1:0] mode_q;
  logic [PIPE_LAT-1:0] vld_q;
  logic pipe_en;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  logic [2:0][NUM_W-1:0] num_d, num_q;
  logic [2:0][DEN_W-1:0] den_d, den_q;
  logic [CH_W-1:0] alpha3_q;
  logic [CH_W-1:0] alpha_p_q [DIV_LAT];
  logic [2:0][CH_W-1:0] quot;
  logic [CH_W-1:0] res_a_q, res_b_q, res_c_q, alpha_out_q;

  assign pipe_en     = !vld_q[PIPE_LAT-1] || out_ready_i;
  assign in_ready_o  = pipe_en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PASS;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  // ---------------- stage 1: extremes, hue numerator, first products
  logic [CH_W-1:0] mx, mn, dd;
  logic [10:0] d6, a6;
  logic signed [11:0] hn_s;
  logic [9:0] a3;
  logic [2:0] sec;

  always_comb begin
    mx = (chan_a_i > chan_b_i) ? chan_a_i : chan_b_i;
    if (chan_c_i > mx) mx = chan_c_i;
    mn = (chan_a_i < chan_b_i) ? chan_a_i : chan_b_i;
    if (chan_c_i < mn) mn = chan_c_i;
    dd = mx - mn;
    d6 = 11'({dd, 2'b0}) + 11'({dd, 1'b0});

    if (mx == chan_a_i) begin
      hn_s = $signed({4'b0, chan_b_i}) - $signed({4'b0, chan_c_i})
           + ((chan_b_i < chan_c_i) ? $signed({1'b0, d6}) : 12'sd0);
    end else if (mx == chan_b_i) begin
      hn_s = $signed({4'b0, chan_c_i}) - $signed({4'b0, chan_a_i})
           + $signed({3'b0, dd, 1'b0});
    end else begin
      hn_s = $signed({4'b0, chan_a_i}) - $signed({4'b0, chan_b_i})
           + $signed({2'b0, dd, 2'b0});
    end

    // hue sector for HSV to RGB; a full-scale hue wraps to sector 0
    a6  = 11'({chan_a_i, 2'b0}) + 11'({chan_a_i, 1'b0});
    sec = '0;
    for (int k = 1; k < 6; k++) begin
      if (a6 >= 11'(255 * k)) sec = 3'(k);
    end
    if (a6 >= 11'd1530) sec = '0;

    a3 = 10'({chan_a_i, 1'b0}) + 10'(chan_a_i);

    s1_d.mode  = mode_q;
    s1_d.a     = chan_a_i;
    s1_d.b     = chan_b_i;
    s1_d.c     = chan_c_i;
    s1_d.alpha = alpha_in_i;
    s1_d.mx    = mx;
    s1_d.d     = dd;
    s1_d.s     = 9'(mx) + 9'(mn);
    s1_d.hn    = hn_s[10:0];
    s1_d.cb    = 16'(chan_c_i) * 16'(chan_b_i);
    s1_d.l     = 17'(chan_c_i) * (17'd510 - 17'(chan_b_i));
    s1_d.lo4   = chan_c_i[7] ? 7'(8'd255 - chan_c_i) : chan_c_i[6:0];
    s1_d.sec   = sec;
    s1_d.f     = (a6 >= 11'd1530) ? '0 : 8'(a6 - 11'(sec) * 11'd255);
    // hue offsets in units of 1/765, wrapped into 0..765
    s1_d.t[0]  = (a3 > 10'd510) ? a3 - 10'd510 : a3 + 10'd255;
    s1_d.t[1]  = a3;
    s1_d.t[2]  = (a3 < 10'd255) ? a3 + 10'd510 : a3 - 10'd255;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) s1_q <= s1_d;
  end

  // ---------------- stage 2: second products, HSL-to-RGB segments
  logic [16:0] c255, b255, q17, p17, l_rest;
  logic [CH_W-1:0] nb;

  always_comb begin
    c255   = (17'(s1_q.c) << 8) - 17'(s1_q.c);
    b255   = (17'(s1_q.b) << 8) - 17'(s1_q.b);
    q17    = s1_q.c[7] ? c255 + b255 - 17'(s1_q.cb) : c255 + 17'(s1_q.cb);
    p17    = (c255 << 1) - q17;
    l_rest = 17'd130050 - s1_q.l;
    nb     = 8'd255 - s1_q.b;

    s2_d.mode  = s1_q.mode;
    s2_d.a     = s1_q.a;
    s2_d.b     = s1_q.b;
    s2_d.c     = s1_q.c;
    s2_d.alpha = s1_q.alpha;
    s2_d.mx    = s1_q.mx;
    s2_d.d     = s1_q.d;
    s2_d.s     = s1_q.s;
    s2_d.hn    = s1_q.hn;
    s2_d.l     = s1_q.l;
    s2_d.lo3   = (s1_q.l < l_rest) ? s1_q.l : l_rest;
    s2_d.n3    = (24'(s1_q.cb) << 8) - 24'(s1_q.cb);
    s2_d.blo   = 15'(s1_q.b) * 15'(s1_q.lo4);
    s2_d.q     = q17[15:0];
    s2_d.p     = p17[15:0];
    s2_d.qmp   = 16'(q17 - p17);
    for (int x = 0; x < 3; x++) begin
      if (s1_q.t[x] <= 10'd127) begin
        s2_d.seg[x] = SEG_RAMP;
        s2_d.k[x]   = 10'(s1_q.t[x] * 10'd6);
      end else if (s1_q.t[x] <= 10'd382) begin
        s2_d.seg[x] = SEG_Q;
        s2_d.k[x]   = '0;
      end else if (s1_q.t[x] < 10'd510) begin
        s2_d.seg[x] = SEG_RAMP;
        s2_d.k[x]   = 10'((10'd510 - s1_q.t[x]) * 10'd6);
      end else begin
        s2_d.seg[x] = SEG_P;
        s2_d.k[x]   = '0;
      end
    end
    s2_d.kp  = (16'(nb) << 8) - 16'(nb);
    s2_d.kq  = 16'd65025 - 16'(s1_q.f) * 16'(s1_q.b);
    s2_d.kt  = 16'd65025 - 16'(8'd255 - s1_q.f) * 16'(s1_q.b);
    s2_d.sec = s1_q.sec;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) s2_q <= s2_d;
  end

  // ---------------- stage 3: dividend and divisor per channel
  logic [NUM_W-1:0] hue_num, d255, blo510, p765, v4n;
  logic [DEN_W-1:0] hue_den, sat_den, v4;
  logic [2:0][NUM_W-1:0] ramp, ck;
  logic [2:0][1:0] pick;

  always_comb begin
    hue_num = (NUM_W'(s2_q.hn) << 8) - NUM_W'(s2_q.hn);
    hue_den = DEN_W'({s2_q.d, 2'b0}) + DEN_W'({s2_q.d, 1'b0});
    d255    = (NUM_W'(s2_q.d) << 8) - NUM_W'(s2_q.d);
    sat_den = (s2_q.s > 9'd255) ? DEN_W'(10'd510 - 10'(s2_q.s)) : DEN_W'(s2_q.s);
    v4      = (DEN_W'(s2_q.c) << 8) - DEN_W'(s2_q.c) + DEN_W'(s2_q.blo);
    v4n     = NUM_W'(v4);
    blo510  = (NUM_W'(s2_q.blo) << 9) - (NUM_W'(s2_q.blo) << 1);
    p765    = NUM_W'(s2_q.p) * NUM_W'(765);

    case (s2_q.sec)
      3'd0:    pick = {PICK_P, PICK_T, PICK_V};
      3'd1:    pick = {PICK_P, PICK_V, PICK_Q};
      3'd2:    pick = {PICK_T, PICK_V, PICK_P};
      3'd3:    pick = {PICK_V, PICK_Q, PICK_P};
      3'd4:    pick = {PICK_V, PICK_P, PICK_T};
      default: pick = {PICK_Q, PICK_P, PICK_V};
    endcase

    for (int x = 0; x < 3; x++) begin
      ramp[x] = p765 + NUM_W'(s2_q.qmp) * NUM_W'(s2_q.k[x]);
      case (pick[x])
        PICK_P:  ck[x] = NUM_W'(s2_q.c) * NUM_W'(s2_q.kp);
        PICK_Q:  ck[x] = NUM_W'(s2_q.c) * NUM_W'(s2_q.kq);
        default: ck[x] = NUM_W'(s2_q.c) * NUM_W'(s2_q.kt);
      endcase
    end

    // byte pass-throughs go through the divider as x / 1
    num_d = {NUM_W'(s2_q.c), NUM_W'(s2_q.b), NUM_W'(s2_q.a)};
    den_d = {3{DEN_W'(1)}};

    case (s2_q.mode)
      MODE_RGB_HSL: begin
        num_d[2] = NUM_W'(s2_q.s >> 1);
        if (s2_q.d == '0) begin
          num_d[0] = '0;
          num_d[1] = '0;
        end else begin
          num_d[1] = d255;
          den_d[1] = sat_den;
          num_d[0] = hue_num;
          den_d[0] = hue_den;
        end
      end
      MODE_RGB_HSV: begin
        num_d[2] = NUM_W'(s2_q.mx);
        num_d[1] = d255;
        den_d[1] = DEN_W'(s2_q.mx);
        num_d[0] = hue_num;
        den_d[0] = hue_den;  // zero for gray, which gives hue 0
      end
      MODE_HSV_HSL: begin
        num_d[2] = NUM_W'(s2_q.l);
        den_d[2] = DEN_W'(510);
        num_d[1] = NUM_W'(s2_q.n3);
        den_d[1] = DEN_W'(s2_q.lo3);
      end
      MODE_HSL_HSV: begin
        num_d[2] = v4n;
        den_d[2] = DEN_W'(255);
        num_d[1] = blo510;
        den_d[1] = v4;
      end
      MODE_HSL_RGB: begin
        if (s2_q.b != '0) begin
          for (int x = 0; x < 3; x++) begin
            case (s2_q.seg[x])
              SEG_RAMP: begin
                num_d[x] = ramp[x];
                den_d[x] = DEN_W'(195075);
              end
              SEG_Q: begin
                num_d[x] = NUM_W'(s2_q.q);
                den_d[x] = DEN_W'(255);
              end
              default: begin
                num_d[x] = NUM_W'(s2_q.p);
                den_d[x] = DEN_W'(255);
              end
            endcase
          end
        end else begin
          num_d = {3{NUM_W'(s2_q.c)}};
        end
      end
      MODE_HSV_RGB: begin
        for (int x = 0; x < 3; x++) begin
          if (pick[x] == PICK_V) begin
            num_d[x] = NUM_W'(s2_q.c);
          end else begin
            num_d[x] = ck[x];
            den_d[x] = DEN_W'(65025);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      num_q    <= num_d;
      den_q    <= den_d;
      alpha3_q <= s2_q.alpha;
    end
  end

  // ---------------- divider stages
  for (genvar x = 0; x < 3; x++) begin : g_div
    pcsc_div u_div (
      .clk_i  (clk_i),
      .en_i   (pipe_en),
      .num_i  (num_q[x]),
      .den_i  (den_q[x]),
      .quot_o (quot[x])
    );
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      alpha_p_q[0] <= alpha3_q;
      for (int i = 1; i < DIV_LAT; i++) alpha_p_q[i] <= alpha_p_q[i-1];
    end
  end

  // ---------------- output register
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      res_a_q     <= quot[0];
      res_b_q     <= quot[1];
      res_c_q     <= quot[2];
      alpha_out_q <= alpha_p_q[DIV_LAT-1];
    end
  end

  assign out_valid_o = vld_q[PIPE_LAT-1];
  assign res_a_o     = res_a_q;
  assign res_b_o     = res_b_q;
  assign res_c_o     = res_c_q;
  assign alpha_out_o = alpha_out_q;

  `ASSERT_AT(a_accept_enters, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> vld_q[0])
  `ASSERT_AT(a_stall_holds, clk_i, rst_ni, !pipe_en |=> ($stable(vld_q) && $stable(res_a_q)))
  `ASSERT_AT(a_cfg_write, clk_i, rst_ni, cfg_valid_i |=> (mode_q == $past(cfg_data_i)))
  `ASSERT_NEVER(a_ready_while_blocked, clk_i, rst_ni, in_ready_o && out_valid_o && !out_ready_i)

endmodule

FILE: tb/pcsc_checker.sv
// Checker for the pixel color space converter: tracks the mode register, predicts
// each converted pixel and compares it with the output words. Depends on pcsc_pkg.
module pcsc_checker import pcsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [MODE_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [CH_W-1:0]   chan_a_i,
  input  logic [CH_W-1:0]   chan_b_i,
  input  logic [CH_W-1:0]   chan_c_i,
  input  logic [CH_W-1:0]   alpha_in_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CH_W-1:0]   res_a_i,
  input  logic [CH_W-1:0]   res_b_i,
  input  logic [CH_W-1:0]   res_c_i,
  input  logic [CH_W-1:0]   alpha_out_i,
  output int                fail_cnt_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CH_W-1:0] a;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] c;
    logic [CH_W-1:0] alpha;
  } pixel_t;

  logic [MODE_W-1:0] conv_mode;
  pixel_t            pixel_q[$];

  assign pending_o = pixel_q.size();

  function automatic longint sat_quot(longint num, longint den);
    longint q;
    if (num <= 0 || den <= 0) return 0;
    q = num / den;
    return q > 255 ? 255 : q;
  endfunction

  function automatic longint hue_byte(longint r, longint g, longint b, longint mx, longint d);
    longint n;
    if (mx == r) n = (g - b) + (g < b ? 6 * d : 0);
    else if (mx == g) n = (b - r) + 2 * d;
    else n = (r - g) + 4 * d;
    return sat_quot(255 * n, 6 * d);
  endfunction

  // t in 1/765 units, p and q in 1/65025 units
  function automatic longint hsl_curve(longint p, longint q, longint t);
    if (t < 0) t += 765;
    if (t > 765) t -= 765;
    if (6 * t < 765) return sat_quot(765 * p + 6 * (q - p) * t, 765 * 255);
    if (2 * t < 765) return sat_quot(q, 255);
    if (3 * t < 1530) return sat_quot(765 * p + 6 * (q - p) * (510 - t), 765 * 255);
    return sat_quot(p, 255);
  endfunction

  function automatic pixel_t convert_pixel(logic [MODE_W-1:0] m, pixel_t px);
    longint a, b, c, mx, mn, d, ra, rb, rc, lt, lo, vt, q, p, sec, f, pv, qv, tv;
    pixel_t r;
    a = px.a; b = px.b; c = px.c;
    ra = a; rb = b; rc = c;
    mx = a > b ? a : b;
    if (c > mx) mx = c;
    mn = a < b ? a : b;
    if (c < mn) mn = c;
    d = mx - mn;
    case (m)
      MODE_RGB_HSL: begin
        rc = (mx + mn) / 2;
        if (d == 0) begin
          ra = 0; rb = 0;
        end else begin
          rb = (mx + mn > 255) ? sat_quot(255 * d, 510 - mx - mn) : sat_quot(255 * d, mx + mn);
          ra = hue_byte(a, b, c, mx, d);
        end
      end
      MODE_RGB_HSV: begin
        rc = mx;
        rb = mx == 0 ? 0 : sat_quot(255 * d, mx);
        ra = d == 0 ? 0 : hue_byte(a, b, c, mx, d);
      end
      MODE_HSV_HSL: begin
        lt = c * (510 - b);
        lo = lt < 130050 - lt ? lt : 130050 - lt;
        rc = sat_quot(lt, 510);
        rb = (lt == 0 || lt == 130050) ? 0 : sat_quot(255 * c * b, lo);
      end
      MODE_HSL_HSV: begin
        lo = c < 255 - c ? c : 255 - c;
        vt = 255 * c + b * lo;
        rc = sat_quot(vt, 255);
        rb = vt == 0 ? 0 : sat_quot(510 * b * lo, vt);
      end
      MODE_HSL_RGB: begin
        if (b == 0) begin
          ra = c; rb = c; rc = c;
        end else begin
          q = c <= 127 ? c * (255 + b) : 255 * c + 255 * b - c * b;
          p = 510 * c - q;
          ra = hsl_curve(p, q, 3 * a + 255);
          rb = hsl_curve(p, q, 3 * a);
          rc = hsl_curve(p, q, 3 * a - 255);
        end
      end
      MODE_HSV_RGB: begin
        sec = (6 * a) / 255;
        f   = 6 * a - 255 * sec;
        pv  = sat_quot(c * (255 - b), 255);
        qv  = sat_quot(c * (65025 - f * b), 65025);
        tv  = sat_quot(c * (65025 - (255 - f) * b), 65025);
        case (sec % 6)
          0: begin ra = c;  rb = tv; rc = pv; end
          1: begin ra = qv; rb = c;  rc = pv; end
          2: begin ra = pv; rb = c;  rc = tv; end
          3: begin ra = pv; rb = qv; rc = c;  end
          4: begin ra = tv; rb = pv; rc = c;  end
          default: begin ra = c; rb = pv; rc = qv; end
        endcase
      end
      default: ;
    endcase
    r.a = ra[7:0]; r.b = rb[7:0]; r.c = rc[7:0]; r.alpha = px.alpha;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      conv_mode  <= MODE_PASS;
      fail_cnt_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) conv_mode <= cfg_data_i;
      if (in_valid_i && in_ready_i)
        pixel_q.push_back(convert_pixel(conv_mode,
                                        '{chan_a_i, chan_b_i, chan_c_i, alpha_in_i}));
      if (out_valid_i && out_ready_i) begin
        if (pixel_q.size() == 0) begin
          $error("output word with nothing expected");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = pixel_q.pop_front();
          if (res_a_i !== want.a || res_b_i !== want.b || res_c_i !== want.c ||
              alpha_out_i !== want.alpha) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (res_a_i !== want.a)
              $error("res_a expected %0d actual %0d", want.a, res_a_i);
            if (res_b_i !== want.b)
              $error("res_b expected %0d actual %0d", want.b, res_b_i);
            if (res_c_i !== want.c)
              $error("res_c expected %0d actual %0d", want.c, res_c_i);
            if (alpha_out_i !== want.alpha)
              $error("alpha_out expected %0d actual %0d", want.alpha, alpha_out_i);
          end
        end
      end
    end
  end
endmodule

FILE: tb/tb_pixel_color_space_converter.sv
// Testbench top for the pixel color space converter: clock, reset, stimulus and
// verdict. Depends on pcsc_pkg, pcsc_checker and the converter RTL.
module tb_pixel_color_space_converter import pcsc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [MODE_W-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CH_W-1:0]   chan_a_i = '0, chan_b_i = '0, chan_c_i = '0, alpha_in_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CH_W-1:0]   res_a_o, res_b_o, res_c_o, alpha_out_o;
  int                fail_cnt, pending;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                quiet_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pixel_color_space_converter DUT (.*);

  pcsc_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .chan_a_i, .chan_b_i, .chan_c_i, .alpha_in_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .res_a_i(res_a_o), .res_b_i(res_b_o), .res_c_i(res_c_o), .alpha_out_i(alpha_out_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("pixel_color_space_converter verification failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] al);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    chan_a_i <= a; chan_b_i <= b; chan_c_i <= c; alpha_in_i <= al;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // weighted byte: extremes and mid values show up often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'(127 + $urandom_range(1));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    logic [7:0] g;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, gray, black, hue 255, lightness ends, zero saturation
    write_mode(MODE_RGB_HSL);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd90, 8'd90, 8'd90, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd10, 8'd2);
    in_valid_i <= 1'b0;
    write_mode(MODE_RGB_HSV);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd3);
    send_pixel(8'd10, 8'd255, 8'd0, 8'd4);
    send_pixel(8'd0, 8'd10, 8'd255, 8'd5);
    in_valid_i <= 1'b0;
    write_mode(MODE_HSV_HSL);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd6);
    send_pixel(8'd0, 8'd0, 8'd255, 8'd7);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd8);
    in_valid_i <= 1'b0;
    write_mode(MODE_HSL_HSV);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd9);
    send_pixel(8'd0, 8'd255, 8'd128, 8'd10);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd11);
    in_valid_i <= 1'b0;
    write_mode(MODE_HSL_RGB);
    send_pixel(8'd77, 8'd0, 8'd200, 8'd12);
    send_pixel(8'd255, 8'd255, 8'd127, 8'd13);
    send_pixel(8'd0, 8'd255, 8'd128, 8'd14);
    in_valid_i <= 1'b0;
    write_mode(MODE_HSV_RGB);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd15);
    send_pixel(8'd213, 8'd128, 8'd200, 8'd16);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd17);
    in_valid_i <= 1'b0;
    write_mode(3'd7);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd128);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd127);
    in_valid_i <= 1'b0;

    // random phases: every mode twice, with the idle pattern changing every two phases
    for (int ph = 0; ph < 16; ph++) begin
      write_mode(3'(ph % 8));
      case ((ph >> 1) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int i = 0; i < 114; i++) begin
        g = pick_byte();
        // gray pixels now and then to hit the max-equals-min path
        if ($urandom_range(15) == 0)
          send_pixel(g, g, g, 8'($urandom_range(255)));
        else
          send_pixel(pick_byte(), pick_byte(), pick_byte(), 8'($urandom_range(255)));
      end
      in_valid_i <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    drain();
    if (fail_cnt == 0 && pending == 0)
      $display("pixel_color_space_converter verification clean");
    else
      $display("pixel_color_space_converter verification failed");
    $finish;
  end
endmodule

FILE: files.f
+incdir+design
design/pcsc_pkg.sv
design/pcsc_div.sv
design/pixel_color_space_converter.sv
tb/pcsc_checker.sv
tb/tb_pixel_color_space_converter.sv
